>>> rtl/three_channel_tone_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-channel tone sequencer
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef THREE_CHANNEL_TONE_SEQUENCER_MACROS_SVH
`define THREE_CHANNEL_TONE_SEQUENCER_MACROS_SVH

// Check that a condition holds at every clock outside reset
`define TCTS_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("three_channel_tone_sequencer: invariant failed");

// Check that a consequent holds in the same cycle as its antecedent
`define TCTS_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("three_channel_tone_sequencer: implication failed");

// Check that a consequent holds in the cycle after its antecedent
`define TCTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("three_channel_tone_sequencer: next-cycle check failed");

`endif

>>> rtl/tcts_pkg.sv
// ----------------------------------------------------------------------------
// Tone sequencer package
// Request and tone types, command codes, pitch table and divider widths.
// ----------------------------------------------------------------------------
package tcts_pkg;

	localparam int SCORE_DEPTH_DEF  = 1024;
	localparam int MAX_COMMANDS_DEF = 64;

	localparam int FREQ_W = 14;
	localparam int DVD_W  = 26;
	localparam int DVS_W  = 12;
	localparam int DCNT_W = 5;

	// request functions
	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_STOP  = 2'd2;
	localparam logic [1:0] FUNC_TICK  = 2'd3;

	// score command codes
	localparam logic [7:0] CMD_NOTE_MAX = 8'hCF;
	localparam logic [7:0] CMD_OCT_LAST = 8'hD7;
	localparam logic [7:0] CMD_TEMPO    = 8'hDA;
	localparam logic [7:0] CMD_VOLUME   = 8'hDC;
	localparam logic [7:0] CMD_LOOP_A   = 8'hFF;
	localparam logic [7:0] CMD_LOOP_B   = 8'hEA;

	typedef struct packed {
		logic [1:0] func;
		logic [1:0] chan_sel;
		logic [9:0] score_addr;
		logic [7:0] score_byte;
	} tcts_req_t;

	typedef struct packed {
		logic [1:0]        chan_out;
		logic [FREQ_W-1:0] freq_hz;
		logic [7:0]        volume;
		logic              runaway;
		logic              last;
	} tcts_tone_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} tcts_div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [FREQ_W-1:0] quot;
	} tcts_div_rsp_t;

	// low 11 bits of the pitch register for table index 1..24
	function automatic logic [10:0] pitch_reg(input logic [4:0] idx);
		logic [15:0] r;
		unique case (idx)
			5'd1:    r = 16'hF82C;
			5'd2:    r = 16'hF89D;
			5'd3:    r = 16'hF907;
			5'd4:    r = 16'hF96B;
			5'd5:    r = 16'hF9CA;
			5'd6:    r = 16'hFA23;
			5'd7:    r = 16'hFA77;
			5'd8:    r = 16'hFAC7;
			5'd9:    r = 16'hFB12;
			5'd10:   r = 16'hFB58;
			5'd11:   r = 16'hFB9B;
			5'd12:   r = 16'hFBDA;
			5'd13:   r = 16'hFC16;
			5'd14:   r = 16'hFC4E;
			5'd15:   r = 16'hFC83;
			5'd16:   r = 16'hFCB5;
			5'd17:   r = 16'hFCE5;
			5'd18:   r = 16'hFD11;
			5'd19:   r = 16'hFD3B;
			5'd20:   r = 16'hFD63;
			5'd21:   r = 16'hFD89;
			5'd22:   r = 16'hFDAC;
			5'd23:   r = 16'hFDCD;
			5'd24:   r = 16'hFDED;
			default: r = 16'h0000;
		endcase
		return r[10:0];
	endfunction

	// operand bytes skipped after a code with no meaning here
	function automatic logic [1:0] skip_extra(input logic [7:0] c);
		logic [1:0] n;
		unique case (c)
			8'hD8, 8'hD9, 8'hDB, 8'hDD, 8'hDE, 8'hE2, 8'hE3, 8'hE4, 8'hE5,
			8'hE6, 8'hEB, 8'hEF, 8'hF0: n = 2'd1;
			8'hE0, 8'hE1, 8'hEE, 8'hFC, 8'hFE: n = 2'd2;
			8'hFB, 8'hFD: n = 2'd3;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

>>> rtl/three_channel_tone_sequencer.sv
// ----------------------------------------------------------------------------
// Three-channel tone sequencer
// Score memories, command interpreter and tone frequency divider.
// ----------------------------------------------------------------------------
// A score write is taken while idle. A stop gives three silence tones. A start,
// or a tick that advances playback, walks the three channels in turn: each
// score byte is read on the single memory read port through S_FETCH and
// S_USE, a loop code rewinds the pointer before the byte at address zero is
// read, and a note also waits on the one-bit-per-cycle divider. A tick that
// does not advance leaves the sequencer idle. Output stalls can hold any of
// these. Tones leave through a pending stage and an output register, and the
// final tone of a request carries last.
module three_channel_tone_sequencer #(
	parameter int SCORE_DEPTH  = tcts_pkg::SCORE_DEPTH_DEF,
	parameter int MAX_COMMANDS = tcts_pkg::MAX_COMMANDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  tcts_pkg::tcts_req_t  req,
	output logic                tone_valid,
	input  logic                tone_stall,
	output tcts_pkg::tcts_tone_t tone
);

	`include "three_channel_tone_sequencer_macros.svh"

	localparam int PW = $clog2(SCORE_DEPTH);
	localparam int AW = $clog2(3 * SCORE_DEPTH);
	localparam int CW = $clog2(MAX_COMMANDS);
	localparam logic [PW:0] DEPTH_W = (PW+1)'(SCORE_DEPTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHAN  = 3'd1;
	localparam logic [2:0] S_FETCH = 3'd2;
	localparam logic [2:0] S_USE   = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	localparam logic [1:0] PH_CMD = 2'd0;
	localparam logic [1:0] PH_HI  = 2'd1;
	localparam logic [1:0] PH_LO  = 2'd2;
	localparam logic [1:0] PH_VOL = 2'd3;

	localparam logic AFTER_NEXT   = 1'b0;
	localparam logic AFTER_INTERP = 1'b1;

	logic [2:0]  state_q;
	logic [1:0]  func_q;
	logic [1:0]  ch_q;
	logic [1:0]  phase_q;
	logic        loop_q;
	logic        after_q;
	logic [CW-1:0] cmd_cnt_q;
	logic        playing_q;
	logic [15:0] tempo_q;
	logic [15:0] ms_q;
	logic [7:0]  tempo_hi_q;

	logic [PW-1:0] ptr_q   [3];
	logic [2:0]    oct_q   [3];
	logic [7:0]    vol_q   [3];
	logic [4:0]    ticks_q [3];

	logic [7:0]  mem_q [3*SCORE_DEPTH];
	logic [7:0]  rdata_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic        wr_en;

	logic        pend_v_q;
	tcts_pkg::tcts_tone_t pend_q;
	tcts_pkg::tcts_tone_t tone_new_q;
	logic        tone_valid_q;
	tcts_pkg::tcts_tone_t tone_q;
	logic        can_push;
	logic        tone_push;

	logic        div_start_q;
	logic [tcts_pkg::DVD_W-1:0] div_dvd_q;
	logic [tcts_pkg::DVS_W-1:0] div_dvs_q;
	tcts_pkg::tcts_div_req_t div_req;
	tcts_pkg::tcts_div_rsp_t div_rsp;

	logic        accept;
	logic [1:0]  ch_idx;
	logic [PW-1:0] cur_ptr;
	logic [2:0]  cur_oct;
	logic [7:0]  cmd;
	logic        is_loop;
	logic        oct_base;
	logic [4:0]  pidx;
	logic [10:0] den;
	logic [2:0]  shamt;
	logic [15:0] ms_next;

	function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [2:0] n);
		logic [PW:0] s;
		s = {1'b0, p} + (PW+1)'(n);
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[PW-1:0];
	endfunction

	function automatic tcts_pkg::tcts_tone_t tone_pending_out(input logic is_last);
		tcts_pkg::tcts_tone_t t;
		t      = pend_q;
		t.last = is_last;
		return t;
	endfunction

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign can_push  = !tone_valid_q || !tone_stall;
	assign tone_push = pend_v_q && can_push && ((state_q == S_EMIT) || (state_q == S_FIN));

	// select the working channel
	assign ch_idx  = (ch_q == 2'd3) ? 2'd0 : ch_q;
	assign cur_ptr = ptr_q[ch_idx];
	assign cur_oct = oct_q[ch_idx];
	assign cmd     = rdata_q;
	assign is_loop = (cmd == tcts_pkg::CMD_LOOP_A) || (cmd == tcts_pkg::CMD_LOOP_B);

	// tone setup: table index, denominator and octave shift
	assign oct_base = (cur_oct >= 3'd2);
	assign pidx     = {1'b0, cmd[7:4]} + (oct_base ? 5'd12 : 5'd0);
	assign den      = 11'd2047 - tcts_pkg::pitch_reg(pidx) + 11'd1;
	assign shamt    = cur_oct - {2'b00, oct_base};

	assign ms_next = (ms_q == 16'hFFFF) ? ms_q : ms_q + 16'd1;

	// score memory ports
	assign wr_en   = accept && (req.func == tcts_pkg::FUNC_WRITE) && (req.chan_sel != 2'd3)
		&& (32'(req.score_addr) < SCORE_DEPTH);
	assign wr_addr = AW'(req.chan_sel) * AW'(SCORE_DEPTH) + AW'(req.score_addr);
	assign rd_addr = AW'(ch_idx) * AW'(SCORE_DEPTH) + AW'(cur_ptr);

	// store score bytes, read one byte a cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= req.score_byte;
		end
		rdata_q <= mem_q[rd_addr];
	end

	assign div_req.start    = div_start_q;
	assign div_req.dividend = div_dvd_q;
	assign div_req.divisor  = div_dvs_q;

	tcts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			func_q       <= tcts_pkg::FUNC_WRITE;
			ch_q         <= 2'd0;
			phase_q      <= PH_CMD;
			loop_q       <= 1'b0;
			after_q      <= AFTER_NEXT;
			cmd_cnt_q    <= '0;
			playing_q    <= 1'b0;
			tempo_q      <= 16'd100;
			ms_q         <= 16'd0;
			pend_v_q     <= 1'b0;
			tone_valid_q <= 1'b0;
			div_start_q  <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				ptr_q[i]   <= '0;
				oct_q[i]   <= 3'd4;
				vol_q[i]   <= 8'd128;
				ticks_q[i] <= 5'd0;
			end
		end else begin
			div_start_q <= 1'b0;
			// load the output register on a push, drop it once taken
			if (tone_push) begin
				tone_valid_q <= 1'b1;
			end else if (tone_valid_q && !tone_stall) begin
				tone_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q <= req.func;
						ch_q   <= 2'd0;
						unique case (req.func)
							tcts_pkg::FUNC_WRITE: ;
							tcts_pkg::FUNC_START: state_q <= S_CHAN;
							tcts_pkg::FUNC_STOP: begin
								playing_q <= 1'b0;
								state_q   <= S_CHAN;
							end
							tcts_pkg::FUNC_TICK: begin
								if (playing_q) begin
									if (ms_next >= tempo_q) begin
										ms_q    <= 16'd0;
										state_q <= S_CHAN;
									end else begin
										ms_q <= ms_next;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_CHAN: begin
					if (ch_q == 2'd3) begin
						if (func_q == tcts_pkg::FUNC_START) begin
							playing_q <= 1'b1;
							ms_q      <= 16'd0;
						end
						state_q <= S_FIN;
					end else begin
						cmd_cnt_q <= '0;
						phase_q   <= PH_CMD;
						loop_q    <= 1'b0;
						priority if (func_q == tcts_pkg::FUNC_START) begin
							ptr_q[ch_idx]   <= '0;
							oct_q[ch_idx]   <= 3'd4;
							vol_q[ch_idx]   <= 8'd128;
							ticks_q[ch_idx] <= 5'd0;
							state_q         <= S_FETCH;
						end else if (func_q == tcts_pkg::FUNC_STOP) begin
							tone_new_q <= '{chan_out: ch_q, freq_hz: '0, volume: '0,
								runaway: 1'b0, last: 1'b0};
							after_q <= AFTER_NEXT;
							state_q <= S_EMIT;
						end else if (ticks_q[ch_idx] != 5'd0) begin
							ticks_q[ch_idx] <= ticks_q[ch_idx] - 5'd1;
							if (ticks_q[ch_idx] == 5'd1) begin
								tone_new_q <= '{chan_out: ch_q, freq_hz: '0, volume: '0,
									runaway: 1'b0, last: 1'b0};
								after_q <= AFTER_INTERP;
								state_q <= S_EMIT;
							end else begin
								ch_q <= ch_q + 2'd1;
							end
						end else begin
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_USE;
				end
				S_USE: begin
					unique case (phase_q)
						PH_CMD: begin
							if (!loop_q && is_loop) begin
								// rewind and read the byte at address zero
								ptr_q[ch_idx] <= '0;
								loop_q        <= 1'b1;
								state_q       <= S_FETCH;
							end else begin
								loop_q        <= 1'b0;
								// step past the code and any operand bytes it carries
								ptr_q[ch_idx] <= ptr_add(cur_ptr,
									3'd1 + {1'b0, tcts_pkg::skip_extra(cmd)});
								priority if (cmd <= tcts_pkg::CMD_NOTE_MAX) begin
									ticks_q[ch_idx] <= (cmd[3:0] == 4'd0) ? 5'd16
										: {1'b0, cmd[3:0]};
									if (cmd[7:4] == 4'd0) begin
										tone_new_q <= '{chan_out: ch_q, freq_hz: '0,
											volume: '0, runaway: 1'b0, last: 1'b0};
										after_q <= AFTER_NEXT;
										state_q <= S_EMIT;
									end else begin
										div_dvd_q   <= (tcts_pkg::DVD_W'(1) << (5'd18 + 5'(shamt)))
											+ tcts_pkg::DVD_W'(den);
										div_dvs_q   <= {den, 1'b0};
										div_start_q <= 1'b1;
										state_q     <= S_DIV;
									end
								end else if (cmd[7:3] == tcts_pkg::CMD_OCT_LAST[7:3]) begin
									oct_q[ch_idx] <= 3'd7 - cmd[2:0];
								end else if (cmd == tcts_pkg::CMD_TEMPO) begin
									phase_q <= PH_HI;
									state_q <= S_FETCH;
								end else if (cmd == tcts_pkg::CMD_VOLUME) begin
									phase_q <= PH_VOL;
									state_q <= S_FETCH;
								end
							end
						end
						PH_HI: begin
							tempo_hi_q    <= cmd;
							ptr_q[ch_idx] <= ptr_add(cur_ptr, 3'd1);
							phase_q       <= PH_LO;
							state_q       <= S_FETCH;
						end
						PH_LO: begin
							tempo_q       <= {tempo_hi_q, cmd};
							ms_q          <= 16'd0;
							ptr_q[ch_idx] <= ptr_add(cur_ptr, 3'd1);
						end
						PH_VOL: begin
							vol_q[ch_idx] <= cmd;
							ptr_q[ch_idx] <= ptr_add(cur_ptr, 3'd1);
						end
						default: ;
					endcase
					// close a command that did not branch elsewhere
					if ((phase_q == PH_LO) || (phase_q == PH_VOL) || ((phase_q == PH_CMD)
						&& (loop_q || !is_loop) && (cmd > tcts_pkg::CMD_NOTE_MAX)
						&& (cmd != tcts_pkg::CMD_TEMPO) && (cmd != tcts_pkg::CMD_VOLUME))) begin
						phase_q <= PH_CMD;
						if (cmd_cnt_q == CW'(MAX_COMMANDS - 1)) begin
							tone_new_q <= '{chan_out: ch_q, freq_hz: '0, volume: '0,
								runaway: 1'b1, last: 1'b0};
							after_q <= AFTER_NEXT;
							state_q <= S_EMIT;
						end else begin
							cmd_cnt_q <= cmd_cnt_q + 1'b1;
							state_q   <= S_FETCH;
						end
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						tone_new_q <= '{chan_out: ch_q, freq_hz: div_rsp.quot,
							volume: vol_q[ch_idx], runaway: 1'b0, last: 1'b0};
						after_q <= AFTER_NEXT;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					// hold the new tone as pending, push the older one out
					if (!pend_v_q || can_push) begin
						if (pend_v_q) begin
							tone_q <= tone_pending_out(1'b0);
						end
						pend_q   <= tone_new_q;
						pend_v_q <= 1'b1;
						if (after_q == AFTER_NEXT) begin
							ch_q    <= ch_q + 2'd1;
							state_q <= S_CHAN;
						end else begin
							cmd_cnt_q <= '0;
							phase_q   <= PH_CMD;
							loop_q    <= 1'b0;
							state_q   <= S_FETCH;
						end
					end
				end
				S_FIN: begin
					// drain the final tone with last set
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (can_push) begin
						tone_q   <= tone_pending_out(1'b1);
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign tone_valid = tone_valid_q;
	assign tone       = tone_q;

	`TCTS_ASSERT_IMPLY(a_idle_no_pending, state_q == S_IDLE, !pend_v_q)
	`TCTS_ASSERT_IMPLY(a_div_only_in_div, div_rsp.busy, state_q == S_DIV)
	`TCTS_ASSERT_NEXT(a_fin_sets_last, (state_q == S_FIN) && pend_v_q && can_push, tone_valid_q && tone_q.last)
	`TCTS_ASSERT_ALWAYS(a_cmd_cnt_range, 32'(cmd_cnt_q) < MAX_COMMANDS)

endmodule

>>> rtl/tcts_div.sv
// ----------------------------------------------------------------------------
// Tone divider
// Restoring divider, one quotient bit per cycle; keeps the low quotient bits.
// ----------------------------------------------------------------------------
module tcts_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tcts_pkg::tcts_div_req_t req,
	output tcts_pkg::tcts_div_rsp_t rsp
);

	logic [tcts_pkg::DVD_W-1:0]  dvd_q;
	logic [tcts_pkg::DVS_W-1:0]  dvs_q;
	logic [tcts_pkg::DVS_W-1:0]  rem_q;
	logic [tcts_pkg::FREQ_W-1:0] quo_q;
	logic [tcts_pkg::DCNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [tcts_pkg::DVS_W:0]    trial;
	logic                        ge;
	logic [tcts_pkg::DVS_W:0]    diff;

	// trial subtract of the divisor from the shifted remainder
	assign trial = {rem_q, dvd_q[tcts_pkg::DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	// control: start loads, count down one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= tcts_pkg::DCNT_W'(tcts_pkg::DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tcts_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift dividend, update remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[tcts_pkg::DVD_W-2:0], 1'b0};
			rem_q <= ge ? diff[tcts_pkg::DVS_W-1:0] : trial[tcts_pkg::DVS_W-1:0];
			quo_q <= {quo_q[tcts_pkg::FREQ_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

>>> tb/sv/three_channel_tone_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-channel tone sequencer testbench
// Plans score writes, starts, stops and ticks against a planning copy of the
// sequencer state. Any byte the interpreter would read before it is written
// gets a note byte written first. Every accepted request is run through a
// checking copy, and each tone leaving the block is compared field by field.
// ----------------------------------------------------------------------------
module three_channel_tone_sequencer_tb;

	localparam int SD        = tcts_pkg::SCORE_DEPTH_DEF;
	localparam int MAXC      = tcts_pkg::MAX_COMMANDS_DEF;
	localparam int LIMIT     = 3000000;
	localparam int IDLE_PCT  = 19;
	localparam int DRAIN_CYC = 2000;

	// state slots: planning copy, checking copy, scratch for dry runs
	localparam int PLAN  = 0;
	localparam int CHECK = 1;
	localparam int DRY   = 2;

	localparam logic [15:0] PITCH_TAB [25] = '{
		16'h0000,
		16'hF82C, 16'hF89D, 16'hF907, 16'hF96B, 16'hF9CA, 16'hFA23, 16'hFA77, 16'hFAC7,
		16'hFB12, 16'hFB58, 16'hFB9B, 16'hFBDA,
		16'hFC16, 16'hFC4E, 16'hFC83, 16'hFCB5, 16'hFCE5, 16'hFD11, 16'hFD3B, 16'hFD63,
		16'hFD89, 16'hFDAC, 16'hFDCD, 16'hFDED
	};
	localparam logic [7:0] SKIP_CODES [20] = '{
		8'hD8, 8'hD9, 8'hDB, 8'hDD, 8'hDE, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6,
		8'hEB, 8'hEF, 8'hF0, 8'hE0, 8'hE1, 8'hEE, 8'hFC, 8'hFE, 8'hFB, 8'hFD
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	tcts_pkg::tcts_req_t  req = '0;
	logic                 tone_valid;
	logic                 tone_stall = 1'b0;
	tcts_pkg::tcts_tone_t tone;

	three_channel_tone_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.tone_valid(tone_valid), .tone_stall(tone_stall), .tone(tone)
	);

	// sequencer state, one copy per slot
	bit [7:0]    score_q  [3][3][SD];
	bit          filled_q [3][3][SD];
	int unsigned ptr_q    [3][3];
	int unsigned oct_q    [3][3];
	int unsigned vol_q    [3][3];
	int unsigned beats_q  [3][3];
	int unsigned tempo_q  [3];
	int unsigned ms_q     [3];
	bit          play_q   [3];
	bit          miss_q   [3];
	int          miss_ch  [3];
	int          miss_addr[3];

	tcts_pkg::tcts_tone_t step_tones[$];
	tcts_pkg::tcts_tone_t tones_due[$];
	tcts_pkg::tcts_req_t  reqs_pending[$];
	int          errors = 0;
	int          cyc = 0;
	int          hold_left = 0;

	task automatic report(input string msg);
		$display("MISMATCH @%0d: %s", cyc, msg);
		errors++;
	endtask

	function automatic void reset_slot(input int m);
		for (int c = 0; c < 3; c++) begin
			for (int a = 0; a < SD; a++) begin
				score_q[m][c][a] = 8'h00;
				filled_q[m][c][a] = 1'b0;
			end
			ptr_q[m][c] = 0;
			oct_q[m][c] = 4;
			vol_q[m][c] = 128;
			beats_q[m][c] = 0;
		end
		tempo_q[m] = 100;
		ms_q[m] = 0;
		play_q[m] = 1'b0;
		miss_q[m] = 1'b0;
	endfunction

	function automatic void copy_slot(input int s, input int d);
		for (int c = 0; c < 3; c++) begin
			for (int a = 0; a < SD; a++) begin
				score_q[d][c][a] = score_q[s][c][a];
				filled_q[d][c][a] = filled_q[s][c][a];
			end
			ptr_q[d][c] = ptr_q[s][c];
			oct_q[d][c] = oct_q[s][c];
			vol_q[d][c] = vol_q[s][c];
			beats_q[d][c] = beats_q[s][c];
		end
		tempo_q[d] = tempo_q[s];
		ms_q[d] = ms_q[s];
		play_q[d] = play_q[s];
		miss_q[d] = 1'b0;
	endfunction

	// read the byte under the pointer, noting the first unwritten one
	function automatic bit [7:0] peek_score(input int m, input int ch);
		if (!filled_q[m][ch][ptr_q[m][ch]] && !miss_q[m]) begin
			miss_q[m] = 1'b1;
			miss_ch[m] = ch;
			miss_addr[m] = int'(ptr_q[m][ch]);
		end
		return score_q[m][ch][ptr_q[m][ch]];
	endfunction

	function automatic bit [7:0] fetch_score(input int m, input int ch);
		bit [7:0] b;
		b = peek_score(m, ch);
		ptr_q[m][ch] = (ptr_q[m][ch] + 1) % SD;
		return b;
	endfunction

	function automatic int unsigned operand_bytes(input bit [7:0] c);
		case (c)
			8'hD8, 8'hD9, 8'hDB, 8'hDD, 8'hDE, 8'hE2, 8'hE3, 8'hE4, 8'hE5,
			8'hE6, 8'hEB, 8'hEF, 8'hF0: return 1;
			8'hE0, 8'hE1, 8'hEE, 8'hFC, 8'hFE: return 2;
			8'hFB, 8'hFD: return 3;
			default: return 0;
		endcase
	endfunction

	// exact round-half-up of 131072 * 2^(oct-base) / (2048 - pitch register)
	function automatic bit [tcts_pkg::FREQ_W-1:0] tone_freq(input int unsigned pitch,
			input int unsigned oct);
		int unsigned     base;
		int unsigned     preg;
		longint unsigned num;
		longint unsigned den;
		longint unsigned q;
		base = (oct < 2) ? 0 : 1;
		preg = 32'(PITCH_TAB[(pitch + base * 12) % 25] & 16'h07FF);
		num = 64'd131072 << ((oct - base) & 7);
		den = 64'(2048 - preg);
		q = (2 * num + den) / (2 * den);
		return q[tcts_pkg::FREQ_W-1:0];
	endfunction

	function automatic void add_tone(input int ch, input int unsigned f,
			input int unsigned v, input bit flag);
		tcts_pkg::tcts_tone_t t;
		t.chan_out = ch[1:0];
		t.freq_hz = f[tcts_pkg::FREQ_W-1:0];
		t.volume = v[7:0];
		t.runaway = flag;
		t.last = 1'b0;
		step_tones.push_back(t);
	endfunction

	// walk one channel's score up to a note or rest, or flag a run-away
	function automatic void play_channel(input int m, input int ch);
		bit [7:0]    cmd;
		bit [7:0]    hi;
		bit [7:0]    lo;
		int unsigned len;
		for (int k = 0; k < MAXC; k++) begin
			cmd = peek_score(m, ch);
			if (cmd == tcts_pkg::CMD_LOOP_A || cmd == tcts_pkg::CMD_LOOP_B)
				ptr_q[m][ch] = 0;
			cmd = fetch_score(m, ch);
			if (cmd <= tcts_pkg::CMD_NOTE_MAX) begin
				len = 32'(cmd[3:0]);
				beats_q[m][ch] = (len != 0) ? len : 16;
				if (cmd[7:4] == 4'd0)
					add_tone(ch, 0, 0, 1'b0);
				else
					add_tone(ch, 32'(tone_freq(32'(cmd[7:4]), oct_q[m][ch])),
						vol_q[m][ch], 1'b0);
				return;
			end
			if (cmd[7:3] == tcts_pkg::CMD_OCT_LAST[7:3]) begin
				oct_q[m][ch] = 32'((tcts_pkg::CMD_OCT_LAST - cmd) & 8'h07);
			end else if (cmd == tcts_pkg::CMD_TEMPO) begin
				hi = fetch_score(m, ch);
				lo = fetch_score(m, ch);
				tempo_q[m] = 32'({hi, lo});
				ms_q[m] = 0;
			end else if (cmd == tcts_pkg::CMD_VOLUME) begin
				vol_q[m][ch] = 32'(fetch_score(m, ch));
			end else if (cmd != tcts_pkg::CMD_LOOP_A && cmd != tcts_pkg::CMD_LOOP_B) begin
				ptr_q[m][ch] = (ptr_q[m][ch] + operand_bytes(cmd)) % SD;
			end
		end
		add_tone(ch, 0, 0, 1'b1);
	endfunction

	// apply one request to a slot; the tones land in step_tones
	function automatic void seq_step(input int m, input tcts_pkg::tcts_req_t r);
		step_tones.delete();
		case (r.func)
			tcts_pkg::FUNC_WRITE: begin
				if (r.chan_sel < 3 && r.score_addr < SD) begin
					score_q[m][r.chan_sel][r.score_addr] = r.score_byte;
					filled_q[m][r.chan_sel][r.score_addr] = 1'b1;
				end
			end
			tcts_pkg::FUNC_START: begin
				for (int c = 0; c < 3; c++) begin
					ptr_q[m][c] = 0;
					oct_q[m][c] = 4;
					vol_q[m][c] = 128;
					beats_q[m][c] = 0;
					play_channel(m, c);
				end
				play_q[m] = 1'b1;
				ms_q[m] = 0;
			end
			tcts_pkg::FUNC_STOP: begin
				play_q[m] = 1'b0;
				for (int c = 0; c < 3; c++)
					add_tone(c, 0, 0, 1'b0);
			end
			default: begin
				if (play_q[m]) begin
					if (ms_q[m] < 16'hFFFF)
						ms_q[m]++;
					if (ms_q[m] >= tempo_q[m]) begin
						ms_q[m] = 0;
						for (int c = 0; c < 3; c++) begin
							if (beats_q[m][c] > 0) begin
								beats_q[m][c]--;
								if (beats_q[m][c] != 0)
									continue;
								add_tone(c, 0, 0, 1'b0);
							end
							play_channel(m, c);
						end
					end
				end
			end
		endcase
		if (step_tones.size() > 0)
			step_tones[step_tones.size()-1].last = 1'b1;
	endfunction

	function automatic tcts_pkg::tcts_req_t make_req(input logic [1:0] f, input int ch,
			input int addr, input int b);
		tcts_pkg::tcts_req_t r;
		r.func = f;
		r.chan_sel = ch[1:0];
		r.score_addr = addr[9:0];
		r.score_byte = b[7:0];
		return r;
	endfunction

	// queue a request; fill any score byte it would read unwritten first
	function automatic void plan(input tcts_pkg::tcts_req_t r);
		tcts_pkg::tcts_req_t w;
		if (r.func != tcts_pkg::FUNC_WRITE) begin
			while (1) begin
				copy_slot(PLAN, DRY);
				seq_step(DRY, r);
				if (!miss_q[DRY])
					break;
				w = make_req(tcts_pkg::FUNC_WRITE, miss_ch[DRY], miss_addr[DRY],
					int'($urandom_range(0, tcts_pkg::CMD_NOTE_MAX)));
				seq_step(PLAN, w);
				reqs_pending.push_back(w);
			end
		end
		seq_step(PLAN, r);
		reqs_pending.push_back(r);
	endfunction

	function automatic void plan_bytes(input int ch, inout int addr,
			input bit [7:0] bytes[$]);
		foreach (bytes[i]) begin
			plan(make_req(tcts_pkg::FUNC_WRITE, ch, addr, 32'(bytes[i])));
			addr++;
		end
	endfunction

	// well-formed score with random content, closed by a loop code
	function automatic void plan_score(input int ch);
		int       addr;
		int       n;
		int       sel;
		bit [7:0] code;
		addr = 0;
		n = int'($urandom_range(3, 12));
		for (int i = 0; i < n; i++) begin
			sel = int'($urandom_range(0, 99));
			if (sel < 45)
				plan_bytes(ch, addr, '{8'($urandom_range(0, tcts_pkg::CMD_NOTE_MAX))});
			else if (sel < 58)
				plan_bytes(ch, addr, '{8'(8'hD0 + $urandom_range(0, 7))});
			else if (sel < 70)
				plan_bytes(ch, addr, '{tcts_pkg::CMD_VOLUME, 8'($urandom_range(0, 255))});
			else if (sel < 82)
				plan_bytes(ch, addr, '{tcts_pkg::CMD_TEMPO, 8'h00, 8'($urandom_range(0, 3))});
			else begin
				code = SKIP_CODES[$urandom_range(0, 19)];
				plan_bytes(ch, addr, '{code});
				for (int j = 0; j < operand_bytes(code); j++)
					plan_bytes(ch, addr, '{8'($urandom_range(0, 255))});
			end
		end
		plan_bytes(ch, addr, '{($urandom_range(0, 1) != 0) ? tcts_pkg::CMD_LOOP_A
			: tcts_pkg::CMD_LOOP_B});
	endfunction

	// clock, cycle count and run limit
	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// drive requests: hold while stalled, else offer the next one or idle
	always @(posedge clk) begin
		bit calm;
		calm = (cyc >= 800 && cyc < 2000);
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!(req_valid && req_stall)) begin
			if (req_valid) begin
				seq_step(CHECK, req);
				foreach (step_tones[i])
					tones_due.push_back(step_tones[i]);
				void'(reqs_pending.pop_front());
			end
			if ((reqs_pending.size() > 0) &&
					(calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				req_valid <= 1'b1;
				req <= reqs_pending[0];
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// drive tone stall: long hold-offs twice, none in a calm window, random stalls otherwise
	always @(posedge clk) begin
		if (!arst_n) begin
			tone_stall <= 1'b0;
		end else if (hold_left > 0) begin
			tone_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (cyc == 100 || cyc == 30000) begin
			tone_stall <= 1'b1;
			hold_left <= 600;
		end else if (cyc >= 800 && cyc < 2000) begin
			tone_stall <= 1'b0;
		end else begin
			tone_stall <= ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// check each accepted tone against the oldest expected one
	always @(posedge clk) begin
		tcts_pkg::tcts_tone_t e;
		if (arst_n && tone_valid && !tone_stall) begin
			if (tones_due.size() == 0) begin
				report($sformatf("unexpected tone ch%0d f%0d", tone.chan_out, tone.freq_hz));
			end else begin
				e = tones_due.pop_front();
				if (tone.chan_out !== e.chan_out)
					report($sformatf("chan_out %0d want %0d", tone.chan_out, e.chan_out));
				if (tone.freq_hz !== e.freq_hz)
					report($sformatf("freq_hz %0d want %0d", tone.freq_hz, e.freq_hz));
				if (tone.volume !== e.volume)
					report($sformatf("volume %0d want %0d", tone.volume, e.volume));
				if (tone.runaway !== e.runaway)
					report($sformatf("runaway %0d want %0d", tone.runaway, e.runaway));
				if (tone.last !== e.last)
					report($sformatf("last %0d want %0d", tone.last, e.last));
			end
		end
	end

	initial begin
		int a0;
		int a1;
		int a2;
		reset_slot(PLAN);
		reset_slot(CHECK);
		// directed: ignored channel, stopped tick, tempo extremes, skips,
		// volume and octave extremes, rests, endless loop run-away
		plan(make_req(tcts_pkg::FUNC_WRITE, 3, 1023, 8'hFF));
		plan(make_req(tcts_pkg::FUNC_TICK, 0, 0, 0));
		a0 = 0;
		plan_bytes(0, a0, '{tcts_pkg::CMD_TEMPO, 8'h12, 8'h34, tcts_pkg::CMD_TEMPO, 8'h00,
			8'h00, tcts_pkg::CMD_VOLUME, 8'hFF, 8'hD0, 8'hCF, 8'hD7, 8'h1F, 8'h00,
			tcts_pkg::CMD_LOOP_A});
		a1 = 0;
		plan_bytes(1, a1, '{8'hD4, tcts_pkg::CMD_LOOP_A});
		a2 = 0;
		plan_bytes(2, a2, '{8'hFB, 8'h01, 8'h02, 8'h03, 8'hD8, 8'hAA, 8'hE0, 8'h55,
			8'h66, tcts_pkg::CMD_VOLUME, 8'h00, 8'h10, tcts_pkg::CMD_LOOP_B});
		plan(make_req(tcts_pkg::FUNC_START, 0, 0, 0));
		for (int i = 0; i < 6; i++)
			plan(make_req(tcts_pkg::FUNC_TICK, 0, 0, 0));
		plan(make_req(tcts_pkg::FUNC_STOP, 0, 0, 0));
		plan(make_req(tcts_pkg::FUNC_TICK, 0, 0, 0));

		// random rounds: fresh scores, start, ticks, stops and noise
		while (reqs_pending.size() < 190) begin
			for (int c = 0; c < 3; c++)
				if ($urandom_range(0, 2) != 0)
					plan_score(c);
			plan(make_req(tcts_pkg::FUNC_START, 0, 0, 0));
			for (int i = int'($urandom_range(8, 30)); i > 0; i--) begin
				case ($urandom_range(0, 19))
					0: plan(make_req(tcts_pkg::FUNC_WRITE, int'($urandom_range(0, 3)),
						int'($urandom_range(0, SD - 1)), int'($urandom_range(0, 255))));
					1: plan(make_req(tcts_pkg::FUNC_START, int'($urandom_range(0, 3)),
						int'($urandom_range(0, SD - 1)), int'($urandom_range(0, 255))));
					2: plan(make_req(tcts_pkg::FUNC_STOP, int'($urandom_range(0, 3)),
						int'($urandom_range(0, SD - 1)), int'($urandom_range(0, 255))));
					default: plan(make_req(tcts_pkg::FUNC_TICK, int'($urandom_range(0, 3)),
						int'($urandom_range(0, SD - 1)), int'($urandom_range(0, 255))));
				endcase
			end
			if ($urandom_range(0, 1) != 0)
				plan(make_req(tcts_pkg::FUNC_STOP, 0, 0, 0));
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// drain: every request taken, every tone seen, then settle
		while (reqs_pending.size() > 0 || req_valid || tones_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tcts_pkg.sv
rtl/tcts_div.sv
rtl/three_channel_tone_sequencer.sv
tb/sv/three_channel_tone_sequencer_tb.sv
